// ===== design/vfc_pkg.sv =====
// Shared types, codes and helpers for the view frustum culling unit.
package vfc_pkg;

   localparam int PLANE_COUNT = 6;

   localparam logic [2:0] CMD_LOAD_PROJ = 3'd0;
   localparam logic [2:0] CMD_LOAD_VIEW = 3'd1;
   localparam logic [2:0] CMD_BUILD     = 3'd2;
   localparam logic [2:0] CMD_POINT     = 3'd3;
   localparam logic [2:0] CMD_SPHERE    = 3'd4;
   localparam logic [2:0] CMD_BOX       = 3'd5;

   typedef struct packed {
      logic [2:0]         command;
      logic [1:0]         major_index;
      logic [1:0]         minor_index;
      logic signed [31:0] value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        extent_x;
      logic [30:0]        extent_y;
      logic [30:0]        extent_z;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_LOAD, S_CLIP_MUL, S_CLIP_ACC, S_CLIP_STORE,
      S_CO0, S_CO1, S_SQ_MUL, S_SQ_ACC, S_SQRT_INIT, S_SQRT, S_MAG,
      S_DIV_INIT, S_DIV, S_COEF, S_T_MUL, S_T_ACC, S_T_EVAL, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LATCH, OP_LOAD_PROJ, OP_LOAD_VIEW, OP_MUL_CLIP, OP_MUL_SQ,
      OP_MUL_TEST, OP_ACC_SHIFT, OP_ACC_RAW, OP_CLIP_STORE, OP_CO,
      OP_SQRT_INIT, OP_SQRT_STEP, OP_COEF_ZERO, OP_DIV_INIT, OP_DIV_STEP,
      OP_COEF_STORE, OP_DIST_EVAL
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;        // sum index, coefficient row or axis
      logic [2:0] plane;
      logic [2:0] corner;
      logic       first;
      logic       phase;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       mag_zero;
      logic       dist_le_zero;
      logic       dist_le_negr;
   } dp_status_type;

   function automatic logic [1:0] plane_col(input logic [2:0] p);
      plane_col = p[2:1];
   endfunction

   // planes w-x, w+x, w+y, w-y, w-z, w+z
   function automatic logic plane_neg(input logic [2:0] p);
      plane_neg = (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF)
         sat32 = 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000)
         sat32 = 32'sh8000_0000;
      else
         sat32 = v[31:0];
   endfunction

endpackage

// ===== design/vfc_datapath.sv =====
// Matrix, clip and plane storage with shared multiply-accumulate, root and divide units.
module vfc_datapath import vfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   localparam int NumW = 32 + FRAC_BITS;

   req_type            req_ff;
   logic signed [31:0] proj_ff  [16];
   logic signed [31:0] view_ff  [16];
   logic signed [31:0] clip_ff  [16];
   logic signed [31:0] plane_ff [24];
   logic signed [31:0] co_ff    [4];
   logic signed [31:0] tmp_ff;
   logic signed [65:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic [63:0]        sq_v_ff;
   logic [63:0]        sq_res_ff;
   logic [63:0]        sq_bit_ff;
   logic [NumW-1:0]    num_ff;
   logic [33:0]        rem_ff;
   logic [NumW-1:0]    quo_ff;

   logic signed [32:0] mul_a, mul_b, coord, pos, half;
   logic [4:0]         plane_addr;
   logic signed [31:0] plane_rd;
   logic [3:0]         clip_addr;
   logic signed [31:0] clip_rd;
   logic signed [65:0] acc_base, dist_sum, neg_r;
   logic [63:0]        sq_t;
   logic [33:0]        mag, rem_sh;
   logic [31:0]        co_abs;
   logic               co_neg;

   always_comb begin
      unique case (cmd.k)
         2'd0: begin
            pos  = 33'(req_ff.pos_x);
            half = {3'b000, req_ff.extent_x[30:1]};
         end
         2'd1: begin
            pos  = 33'(req_ff.pos_y);
            half = {3'b000, req_ff.extent_y[30:1]};
         end
         default: begin
            pos  = 33'(req_ff.pos_z);
            half = {3'b000, req_ff.extent_z[30:1]};
         end
      endcase
      if (req_ff.command != CMD_BOX)
         coord = pos;
      else if (cmd.corner[cmd.k])
         coord = pos + half;
      else
         coord = pos - half;

      plane_addr = (cmd.op == OP_DIST_EVAL) ? {cmd.plane, 2'd3} : {cmd.plane, cmd.k};
      plane_rd   = plane_ff[plane_addr];
      clip_addr  = cmd.phase ? {cmd.k, plane_col(cmd.plane)} : {cmd.k, 2'd3};
      clip_rd    = clip_ff[clip_addr];

      unique case (cmd.op)
         OP_MUL_CLIP: begin
            mul_a = 33'(view_ff[{cmd.i, cmd.k}]);
            mul_b = 33'(proj_ff[{cmd.k, cmd.j}]);
         end
         OP_MUL_SQ: begin
            mul_a = 33'(co_ff[cmd.k]);
            mul_b = 33'(co_ff[cmd.k]);
         end
         default: begin
            mul_a = 33'(plane_rd);
            mul_b = coord;
         end
      endcase

      acc_base = cmd.first ? '0 : acc_ff;
      dist_sum = acc_ff + 66'(plane_rd);
      neg_r    = -66'(req_ff.value);
      sq_t     = sq_res_ff + sq_bit_ff;
      mag      = sq_res_ff[33:0];
      rem_sh   = {rem_ff[32:0], num_ff[NumW-1]};
      co_neg   = co_ff[cmd.k][31];
      co_abs   = co_neg ? 32'(-co_ff[cmd.k]) : 32'(co_ff[cmd.k]);
   end

   assign status.cmd          = req_ff.command;
   assign status.mag_zero     = (sq_res_ff == '0);
   assign status.dist_le_zero = (dist_sum <= 66'sd0);
   assign status.dist_le_negr = (dist_sum <= neg_r);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 16; n++) begin
            proj_ff[n] <= '0;
            view_ff[n] <= '0;
         end
         for (int n = 0; n < 24; n++)
            plane_ff[n] <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD_PROJ:
               proj_ff[{req_ff.major_index, req_ff.minor_index}] <= req_ff.value;
            OP_LOAD_VIEW:
               view_ff[{req_ff.major_index, req_ff.minor_index}] <= req_ff.value;
            OP_COEF_ZERO:
               for (int n = 0; n < 4; n++)
                  plane_ff[{cmd.plane, 2'(n)}] <= '0;
            OP_COEF_STORE: begin
               if (!co_neg)
                  plane_ff[plane_addr] <= (quo_ff > NumW'(64'h7FFF_FFFF)) ?
                                          32'sh7FFF_FFFF : quo_ff[31:0];
               else
                  plane_ff[plane_addr] <= (quo_ff > NumW'(64'h8000_0000)) ?
                                          32'sh8000_0000 : -quo_ff[31:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LATCH:      req_ff <= req_data;
         OP_MUL_CLIP, OP_MUL_SQ, OP_MUL_TEST:
                        prod_ff <= mul_a * mul_b;
         OP_ACC_SHIFT:  acc_ff <= acc_base + (prod_ff >>> FRAC_BITS);
         OP_ACC_RAW:    acc_ff <= acc_base + prod_ff;
         OP_CLIP_STORE: clip_ff[{cmd.i, cmd.j}] <= sat32(acc_ff);
         OP_CO: begin
            if (!cmd.phase)
               tmp_ff <= clip_rd;
            else if (plane_neg(cmd.plane))
               co_ff[cmd.k] <= sat32(66'(tmp_ff) - 66'(clip_rd));
            else
               co_ff[cmd.k] <= sat32(66'(tmp_ff) + 66'(clip_rd));
         end
         OP_SQRT_INIT: begin
            sq_v_ff   <= acc_ff[63:0];
            sq_res_ff <= '0;
            sq_bit_ff <= 64'h4000_0000_0000_0000;
         end
         OP_SQRT_STEP: begin
            if (sq_v_ff >= sq_t) begin
               sq_v_ff   <= sq_v_ff - sq_t;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_DIV_INIT: begin
            num_ff <= NumW'({co_abs, {FRAC_BITS{1'b0}}});
            rem_ff <= '0;
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            num_ff <= num_ff << 1;
            if (rem_sh >= mag) begin
               rem_ff <= rem_sh - mag;
               quo_ff <= {quo_ff[NumW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[NumW-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== design/vfc_ctrl.sv =====
// Sequencer for loads, plane building and the object tests.
module vfc_ctrl import vfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam int DivSteps = 32 + FRAC_BITS;
   localparam int CntW     = $clog2(DivSteps);

   state_type       state_ff, state_in;
   logic [1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [2:0]      p_ff, p_in, c_ff, c_in;
   logic [CntW-1:0] step_ff, step_in;
   logic            inside_ff, inside_in, deg_ff, deg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         p_ff      <= '0;
         c_ff      <= '0;
         step_ff   <= '0;
         inside_ff <= 1'b0;
         deg_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         p_ff      <= p_in;
         c_ff      <= c_in;
         step_ff   <= step_in;
         inside_ff <= inside_in;
         deg_ff    <= deg_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      c_in      = c_ff;
      step_in   = step_ff;
      inside_in = inside_ff;
      deg_in    = deg_ff;
      cmd       = '{op: OP_NOP, i: i_ff, j: j_ff, k: k_ff, plane: p_ff,
                    corner: c_ff, first: (k_ff == 2'd0), phase: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            inside_in = 1'b0;
            deg_in    = 1'b0;
            i_in      = '0;
            j_in      = '0;
            k_in      = '0;
            p_in      = '0;
            c_in      = '0;
            unique case (status.cmd)
               CMD_LOAD_PROJ, CMD_LOAD_VIEW: state_in = S_LOAD;
               CMD_BUILD:                    state_in = S_CLIP_MUL;
               CMD_POINT, CMD_SPHERE, CMD_BOX: begin
                  inside_in = 1'b1;
                  state_in  = S_T_MUL;
               end
               default:                      state_in = S_DONE;
            endcase
         end
         S_LOAD: begin
            cmd.op   = (status.cmd == CMD_LOAD_PROJ) ? OP_LOAD_PROJ : OP_LOAD_VIEW;
            state_in = S_DONE;
         end
         S_CLIP_MUL: begin
            cmd.op   = OP_MUL_CLIP;
            state_in = S_CLIP_ACC;
         end
         S_CLIP_ACC: begin
            cmd.op = OP_ACC_SHIFT;
            if (k_ff == 2'd3) begin
               state_in = S_CLIP_STORE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_CLIP_MUL;
            end
         end
         S_CLIP_STORE: begin
            cmd.op   = OP_CLIP_STORE;
            k_in     = '0;
            j_in     = j_ff + 2'd1;
            state_in = S_CLIP_MUL;
            if (j_ff == 2'd3) begin
               i_in = i_ff + 2'd1;
               if (i_ff == 2'd3)
                  state_in = S_CO0;
            end
         end
         S_CO0: begin
            cmd.op   = OP_CO;
            state_in = S_CO1;
         end
         S_CO1: begin
            cmd.op    = OP_CO;
            cmd.phase = 1'b1;
            k_in      = k_ff + 2'd1;
            state_in  = (k_ff == 2'd3) ? S_SQ_MUL : S_CO0;
         end
         S_SQ_MUL: begin
            cmd.op   = OP_MUL_SQ;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.op = OP_ACC_RAW;
            if (k_ff == 2'd2) begin
               k_in     = '0;
               state_in = S_SQRT_INIT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_SQ_MUL;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            step_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op  = OP_SQRT_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == CntW'(31)) begin
               step_in  = '0;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            if (status.mag_zero) begin
               cmd.op = OP_COEF_ZERO;
               deg_in = 1'b1;
               k_in   = '0;
               p_in   = p_ff + 3'd1;
               state_in = (p_ff == 3'(PLANE_COUNT - 1)) ? S_DONE : S_CO0;
            end else begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == CntW'(DivSteps - 1)) begin
               step_in  = '0;
               state_in = S_COEF;
            end
         end
         S_COEF: begin
            cmd.op = OP_COEF_STORE;
            k_in   = k_ff + 2'd1;
            if (k_ff != 2'd3)
               state_in = S_DIV_INIT;
            else begin
               p_in     = p_ff + 3'd1;
               state_in = (p_ff == 3'(PLANE_COUNT - 1)) ? S_DONE : S_CO0;
            end
         end
         S_T_MUL: begin
            cmd.op   = OP_MUL_TEST;
            state_in = S_T_ACC;
         end
         S_T_ACC: begin
            cmd.op = OP_ACC_SHIFT;
            if (k_ff == 2'd2) begin
               k_in     = '0;
               state_in = S_T_EVAL;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_T_MUL;
            end
         end
         S_T_EVAL: begin
            logic fail, next_plane;
            fail       = 1'b0;
            next_plane = 1'b0;
            cmd.op     = OP_DIST_EVAL;
            priority case (status.cmd)
               CMD_POINT:  if (status.dist_le_zero) fail = 1'b1; else next_plane = 1'b1;
               CMD_SPHERE: if (status.dist_le_negr) fail = 1'b1; else next_plane = 1'b1;
               default: begin
                  // box: one corner in front of the plane clears it
                  if (!status.dist_le_zero)
                     next_plane = 1'b1;
                  else if (c_ff == 3'd7)
                     fail = 1'b1;
                  else begin
                     c_in     = c_ff + 3'd1;
                     state_in = S_T_MUL;
                  end
               end
            endcase
            if (fail) begin
               inside_in = 1'b0;
               state_in  = S_DONE;
            end else if (next_plane) begin
               c_in     = '0;
               p_in     = p_ff + 3'd1;
               state_in = (p_ff == 3'(PLANE_COUNT - 1)) ? S_DONE : S_T_MUL;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_DONE);
   assign rsp_data.inside_res = inside_ff;
   assign rsp_data.degenerate = deg_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid) else $error("result strobe not single");
   a_deg_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(inside_ff && deg_ff)) else $error("degenerate with inside set");
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> p_ff <= 3'(PLANE_COUNT)) else $error("plane counter overrun");

endmodule

// ===== design/view_frustum_culling_unit.sv =====
// Point/sphere test: three multiply-accumulates per plane; the box test repeats them per corner.
// Build: 64 clip products plus 16 stores, then per plane a square root and four divides.
// Cost is set by the single shared multiplier, the bit-serial root and divider.
// One word at a time; busy high until the one-cycle result strobe ends.
// Synchronous reset clears matrices and planes to zero and returns to idle.
module view_frustum_culling_unit import vfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   vfc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   vfc_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (dp_cmd),
      .status   (dp_status)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for the view frustum culling unit: fixed-point plane model and scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vfc_pkg::*;

   localparam int FRAC = 16;
   localparam int ONE = 1 << FRAC;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   view_frustum_culling_unit #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   logic signed [31:0] proj_m [16];
   logic signed [31:0] view_m [16];
   logic signed [31:0] planes [24];
   rsp_type expected_q [$];
   int errors = 0;
   int burst_left = 0;

   function automatic longint fshift(longint v);
      return v >>> FRAC;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint plane_distance(int p, longint x, longint y, longint z);
      return fshift(longint'(planes[p*4]) * x) + fshift(longint'(planes[p*4+1]) * y)
           + fshift(longint'(planes[p*4+2]) * z) + longint'(planes[p*4+3]);
   endfunction

   function automatic logic extract_planes();
      logic signed [31:0] clip [4][4];
      longint acc, co [4], mag, q;
      longint unsigned sq;
      logic deg;
      int col;
      deg = 0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
               acc += fshift(longint'(view_m[i*4+k]) * longint'(proj_m[k*4+j]));
            clip[i][j] = clamp32(acc);
         end
      for (int p = 0; p < 6; p++) begin
         col = p / 2;
         for (int r = 0; r < 4; r++) begin
            if (p == 0 || p == 3 || p == 4)
               co[r] = clamp32(longint'(clip[r][3]) - longint'(clip[r][col]));
            else
               co[r] = clamp32(longint'(clip[r][3]) + longint'(clip[r][col]));
         end
         sq = 0;
         for (int r = 0; r < 3; r++) sq += longint'(co[r] * co[r]);
         mag = int_root(sq);
         for (int r = 0; r < 4; r++) begin
            if (mag == 0) begin
               planes[p*4+r] = 0;
            end else begin
               q = (co[r] * (64'sd1 <<< FRAC)) / mag;
               planes[p*4+r] = clamp32(q);
            end
         end
         if (mag == 0) deg = 1;
      end
      return deg;
   endfunction

   function automatic rsp_type predict_cull(req_type r);
      rsp_type o;
      longint px, py, pz, hx, hy, hz, x, y, z;
      logic any;
      o = '0;
      px = r.pos_x; py = r.pos_y; pz = r.pos_z;
      hx = r.extent_x >> 1; hy = r.extent_y >> 1; hz = r.extent_z >> 1;
      case (r.command)
         CMD_LOAD_PROJ: proj_m[{r.major_index, r.minor_index}] = r.value;
         CMD_LOAD_VIEW: view_m[{r.major_index, r.minor_index}] = r.value;
         CMD_BUILD: o.degenerate = extract_planes();
         CMD_POINT: begin
            o.inside_res = 1;
            for (int p = 0; p < 6; p++)
               if (plane_distance(p, px, py, pz) <= 0) o.inside_res = 0;
         end
         CMD_SPHERE: begin
            o.inside_res = 1;
            for (int p = 0; p < 6; p++)
               if (plane_distance(p, px, py, pz) <= -longint'(r.value)) o.inside_res = 0;
         end
         CMD_BOX: begin
            o.inside_res = 1;
            for (int p = 0; p < 6; p++) begin
               any = 0;
               for (int c = 0; c < 8; c++) begin
                  x = c[0] ? px + hx : px - hx;
                  y = c[1] ? py + hy : py - hy;
                  z = c[2] ? pz + hz : pz - hz;
                  if (plane_distance(p, x, y, z) > 0) any = 1;
               end
               if (!any) o.inside_res = 0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word %b", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_q.pop_front();
            if (e.inside_res !== rsp_data.inside_res || e.degenerate !== rsp_data.degenerate) begin
               $display("%0t: mismatch expected inside=%b deg=%b actual inside=%b deg=%b",
                        $time, e.inside_res, e.degenerate,
                        rsp_data.inside_res, rsp_data.degenerate);
               errors++;
            end
         end
      end
   end

   // start drops after acceptance; the unit ignores start while busy anyway
   task automatic send_word(req_type r);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      repeat (gap) @(posedge clock);
      start <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(predict_cull(r));
      start <= 0;
      @(posedge clock);
   endtask

   function automatic req_type blank(logic [2:0] c);
      req_type r;
      r = '0;
      r.command = c;
      return r;
   endfunction

   task automatic load(logic [2:0] c, int mj, int mn, logic signed [31:0] v);
      req_type r;
      r = blank(c);
      r.major_index = 2'(mj);
      r.minor_index = 2'(mn);
      r.value = v;
      send_word(r);
   endtask

   function automatic logic signed [31:0] small_q();
      return $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
   endfunction

   function automatic req_type rand_word();
      req_type r;
      r = '0;
      r.command = 3'($urandom_range(0, 7));
      r.major_index = 2'($urandom);
      r.minor_index = 2'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         r.value = $urandom; r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
         r.extent_x = 31'($urandom); r.extent_y = 31'($urandom); r.extent_z = 31'($urandom);
      end else begin
         r.value = small_q();
         r.pos_x = small_q() * 4; r.pos_y = small_q() * 4; r.pos_z = small_q() * 4;
         r.extent_x = 31'($urandom_range(0, 4 * ONE));
         r.extent_y = 31'($urandom_range(0, 4 * ONE));
         r.extent_z = 31'($urandom_range(0, 4 * ONE));
      end
      return r;
   endfunction

   task automatic wait_drain();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_zero_planes();
      req_type r;
      send_word(blank(CMD_POINT));
      send_word(blank(CMD_BUILD));
      r = blank(CMD_SPHERE);
      r.value = -1;
      send_word(r);
      send_word(blank(CMD_BOX));
      send_word(blank(CMD_SPARE6));
      send_word(blank(CMD_SPARE7));
   endtask

   task automatic test_identity_frustum();
      req_type r;
      for (int i = 0; i < 4; i++) begin
         load(CMD_LOAD_PROJ, i, i, ONE);
         load(CMD_LOAD_VIEW, i, i, ONE);
      end
      send_word(blank(CMD_BUILD));
      r = blank(CMD_POINT);
      send_word(r);
      r.pos_x = ONE / 2;
      send_word(r);
      r = blank(CMD_SPHERE);
      r.pos_x = 3 * ONE; r.value = 4 * ONE;
      send_word(r);
      r = blank(CMD_BOX);
      r.pos_x = 32'sh7FFF_FFFF; r.pos_y = 32'sh8000_0000;
      r.extent_x = 31'h7FFF_FFFF; r.extent_y = 31'h7FFF_FFFF; r.extent_z = 31'h7FFF_FFFF;
      send_word(r);
      r = blank(CMD_SPHERE);
      r.value = 32'sh8000_0000;
      send_word(r);
      load(CMD_LOAD_PROJ, 0, 0, 32'sh7FFF_FFFF);
      load(CMD_LOAD_VIEW, 3, 3, 32'sh8000_0000);
      send_word(blank(CMD_BUILD));
   endtask

   task automatic test_random();
      req_type r;
      for (int n = 0; n < 400; n++) begin
         if (n % 50 == 0) begin
            // fresh well-formed matrix set followed by a build
            for (int i = 0; i < 16; i++) begin
               load(CMD_LOAD_PROJ, i / 4, i % 4, (i / 4 == i % 4) ? ONE + small_q() / 4 : small_q() / 4);
               load(CMD_LOAD_VIEW, i / 4, i % 4, (i / 4 == i % 4) ? ONE + small_q() / 4 : small_q() / 4);
            end
            send_word(blank(CMD_BUILD));
         end
         if (n == 200) wait_drain();
         r = rand_word();
         if (r.command <= CMD_LOAD_VIEW && $urandom_range(0, 3) != 0)
            r.command = 3'($urandom_range(CMD_POINT, CMD_BOX));
         send_word(r);
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         proj_m[i] = 0;
         view_m[i] = 0;
      end
      for (int i = 0; i < 24; i++) planes[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_zero_planes();
      test_identity_frustum();
      test_random();
      wait_drain();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/vfc_pkg.sv
design/vfc_datapath.sv
design/vfc_ctrl.sv
design/view_frustum_culling_unit.sv
tb/sv/tb.sv
